@@ rtl/kwm_pkg.sv @@
// shared types and constants for the k-way sorted merge
`default_nettype none

package kwm_pkg;

  localparam int VALUE_W     = 32;
  localparam int LIST_NUM_W  = 3;
  localparam int MAX_RESULTS = 64;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_MERGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/kwm_if.sv @@
// handshake channels for input items and merged results
`default_nettype none

interface kwm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [kwm_pkg::LIST_NUM_W-1:0]      list_number;
  logic signed [kwm_pkg::VALUE_W-1:0]  element_value;

  modport source (output valid, action, list_number, element_value, input ready);
  modport sink   (input valid, action, list_number, element_value, output ready);
endinterface

interface kwm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kwm_pkg::VALUE_W-1:0]  merged_value;
  logic                                last_of_merge;
  logic                                dropped_any;

  modport source (output valid, merged_value, last_of_merge, dropped_any, input ready);
  modport sink   (input valid, merged_value, last_of_merge, dropped_any, output ready);
endinterface

`default_nettype wire

@@ rtl/kwm_store.sv @@
// element store: one write port, one registered read port
`default_nettype none

module kwm_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [AW-1:0]                      wr_addr,
  input  wire logic signed [kwm_pkg::VALUE_W-1:0] wr_data,
  input  wire logic                               rd_en,
  input  wire logic [AW-1:0]                      rd_addr,
  output logic signed [kwm_pkg::VALUE_W-1:0]      rd_data
);

  logic signed [kwm_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/k_way_sorted_merge.sv @@
// k-way sorted merge: list loader, head scan sequencer and result register
//
//   channel   dir   payload                                        transaction
//   items     in    action, list_number, element_value             valid & ready
//   results   out   merged_value, last_of_merge, dropped_any       valid & ready
//
// a merge finds each result with one comparator that walks the list heads
// through the single store read port, whose read data is registered, and then
// loads the result register
// items.ready is high only while idle; a result stall holds the sequencer in its emit step
// synchronous reset empties every list and clears the drop flag; store contents are not reset
`default_nettype none

module k_way_sorted_merge #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  kwm_in_if.sink     items,
  kwm_out_if.source  results
);

  localparam int LW      = $clog2(NUM_LISTS);
  localparam int CW      = $clog2(LIST_DEPTH + 1);
  localparam int SW      = $clog2(NUM_LISTS + 1);
  localparam int ENTRIES = NUM_LISTS * LIST_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW      = $clog2(ENTRIES + 1);
  localparam int EW      = $clog2(kwm_pkg::MAX_RESULTS);

  kwm_pkg::state_t state;

  logic [CW-1:0] fill [NUM_LISTS];
  logic [CW-1:0] pos  [NUM_LISTS];
  logic          overflow;
  logic [RW-1:0] remaining;
  logic [EW-1:0] emitted;
  logic [SW-1:0] scan_idx;
  logic          cand_valid;
  logic [LW-1:0] cand_list;
  logic          found;
  logic signed [kwm_pkg::VALUE_W-1:0] best_val;
  logic [LW-1:0] best_list;

  logic                               out_valid;
  logic signed [kwm_pkg::VALUE_W-1:0] out_value;
  logic                               out_last;
  logic                               out_drop;

  logic [LW-1:0] idx;
  logic [CW-1:0] fill_sel;
  logic [CW-1:0] pos_sel;
  logic          accept;
  logic          list_ok;
  logic          do_append;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic signed [kwm_pkg::VALUE_W-1:0] rd_data;
  logic          cand_take;
  logic          out_free;
  logic          is_last;

  // one shared list index: append target, scanned list, or winning list
  always_comb begin
    case (state)
      kwm_pkg::ST_IDLE: idx = LW'(items.list_number);
      kwm_pkg::ST_SCAN: idx = scan_idx[LW-1:0];
      kwm_pkg::ST_EMIT: idx = best_list;
      default:          idx = best_list;
    endcase
  end

  assign fill_sel  = fill[idx];
  assign pos_sel   = pos[idx];
  assign accept    = items.valid & items.ready;
  assign list_ok   = int'(items.list_number) < NUM_LISTS;
  assign do_append = accept && (items.action == kwm_pkg::ACT_APPEND) && list_ok
                     && (fill_sel < CW'(LIST_DEPTH));
  assign wr_addr   = AW'(int'(idx) * LIST_DEPTH + int'(fill_sel));
  assign rd_addr   = AW'(int'(idx) * LIST_DEPTH + int'(pos_sel));
  assign rd_en     = (state == kwm_pkg::ST_SCAN) && (scan_idx < SW'(NUM_LISTS));
  assign cand_take = cand_valid && (!found || (rd_data < best_val));
  assign out_free  = !out_valid || results.ready;
  assign is_last   = (remaining == RW'(1)) || (emitted == EW'(kwm_pkg::MAX_RESULTS - 1));

  assign items.ready           = (state == kwm_pkg::ST_IDLE);
  assign results.valid         = out_valid;
  assign results.merged_value  = out_value;
  assign results.last_of_merge = out_last;
  assign results.dropped_any   = out_drop;

  kwm_store #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_append),
    .wr_addr (wr_addr),
    .wr_data (items.element_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kwm_pkg::ST_IDLE;
      overflow   <= 1'b0;
      remaining  <= '0;
      emitted    <= '0;
      scan_idx   <= '0;
      cand_valid <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill[i] <= '0;
        pos[i]  <= '0;
      end
    end else begin
      if (state == kwm_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        kwm_pkg::ST_IDLE: begin
          if (accept) begin
            if (items.action == kwm_pkg::ACT_APPEND) begin
              if (do_append) begin
                fill[idx] <= fill_sel + CW'(1);
                remaining <= remaining + RW'(1);
              end else if (list_ok) begin
                overflow <= 1'b1;
              end
            end else if (remaining == '0) begin
              // nothing stored: no results, flag still clears
              overflow <= 1'b0;
            end else begin
              state      <= kwm_pkg::ST_SCAN;
              scan_idx   <= '0;
              found      <= 1'b0;
              cand_valid <= 1'b0;
            end
          end
        end

        kwm_pkg::ST_SCAN: begin
          // head read issued last cycle is compared now
          if (cand_take) begin
            found     <= 1'b1;
            best_val  <= rd_data;
            best_list <= cand_list;
          end
          if (scan_idx < SW'(NUM_LISTS)) begin
            cand_valid <= pos_sel < fill_sel;
            cand_list  <= idx;
            scan_idx   <= scan_idx + SW'(1);
          end else begin
            cand_valid <= 1'b0;
            state      <= kwm_pkg::ST_EMIT;
          end
        end

        kwm_pkg::ST_EMIT: begin
          if (out_free) begin
            out_value <= best_val;
            out_last  <= is_last;
            out_drop  <= overflow;
            if (is_last) begin
              for (int i = 0; i < NUM_LISTS; i++) begin
                fill[i] <= '0;
                pos[i]  <= '0;
              end
              overflow  <= 1'b0;
              remaining <= '0;
              emitted   <= '0;
              state     <= kwm_pkg::ST_IDLE;
            end else begin
              pos[idx]  <= pos_sel + CW'(1);
              remaining <= remaining - RW'(1);
              emitted   <= emitted + EW'(1);
              scan_idx  <= '0;
              found     <= 1'b0;
              state     <= kwm_pkg::ST_SCAN;
            end
          end
        end

        default: begin
          state <= kwm_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
